FILE: hw/rtl/esds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esds_pkg
// Shared types and constants of the esds audio config parser: the byte and
// result payloads and the sampling rate table.
// ----------------------------------------------------------------------------
package esds_pkg;

    localparam int unsigned LEN_W  = 12;
    localparam int unsigned RATE_W = 17;

    // Tag bytes, skip count and minimum config size of the descriptor
    localparam logic [7:0] TAG_DEC_CONFIG  = 8'h04;
    localparam logic [7:0] TAG_DEC_SPECIFIC = 8'h05;
    localparam logic [3:0] SKIP_AFTER_CODEC = 4'd12;
    localparam logic [LEN_W-1:0] MIN_CONFIG_SIZE = 12'd2;

    // Result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // One descriptor byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } t_in_item;

    // One parse result
    typedef struct packed {
        logic              status;
        logic [7:0]        codec_id;
        logic [4:0]        object_type;
        logic [3:0]        rate_index;
        logic [RATE_W-1:0] sample_rate;
        logic [3:0]        channel_config;
        logic [LEN_W-1:0]  config_offset;
        logic [LEN_W-1:0]  config_size;
    } t_out_item;

    // Sampling frequency index to rate in Hz; reserved indices give zero
    function automatic logic [RATE_W-1:0] rate_lookup(input logic [3:0] idx);
        logic [RATE_W-1:0] rate;
        unique case (idx)
            4'd0:    rate = 17'd96000;
            4'd1:    rate = 17'd88200;
            4'd2:    rate = 17'd64000;
            4'd3:    rate = 17'd48000;
            4'd4:    rate = 17'd44100;
            4'd5:    rate = 17'd32000;
            4'd6:    rate = 17'd24000;
            4'd7:    rate = 17'd22050;
            4'd8:    rate = 17'd16000;
            4'd9:    rate = 17'd12000;
            4'd10:   rate = 17'd11025;
            4'd11:   rate = 17'd8000;
            default: rate = '0;
        endcase
        return rate;
    endfunction

endpackage

FILE: hw/rtl/esds_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esds_in_reg
// Input register: holds one accepted byte until the parse stage takes it.
// ----------------------------------------------------------------------------
module esds_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  esds_pkg::t_in_item  i_item,
    input  logic                i_advance,
    output logic                o_valid,
    output esds_pkg::t_in_item  o_item
);
    import esds_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     accept;

    // Stall only while a held byte cannot move on this cycle
    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;
    assign n_valid = accept || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload, loaded on each transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: hw/rtl/esds_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esds_parse
// Parse stage: tag/size walk over the descriptor one byte per step, held
// fields, and the result built on the descriptor's last byte.
// ----------------------------------------------------------------------------
module esds_parse #(
    parameter int unsigned MAX_DESCRIPTOR_BYTES = 4095
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  esds_pkg::t_in_item           i_item,
    input  logic [esds_pkg::LEN_W-1:0]   i_length,
    output logic                         o_res_valid,
    output esds_pkg::t_out_item          o_res
);
    import esds_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_DESCRIPTOR_BYTES + 1);
    localparam int unsigned CW    = (POS_W > LEN_W) ? POS_W : LEN_W;

    // Parse phases
    localparam logic [3:0] PH_SEEK4 = 4'd0;
    localparam logic [3:0] PH_SIZE4 = 4'd1;
    localparam logic [3:0] PH_CODEC = 4'd2;
    localparam logic [3:0] PH_SKIP  = 4'd3;
    localparam logic [3:0] PH_TAG5  = 4'd4;
    localparam logic [3:0] PH_SIZE5 = 4'd5;
    localparam logic [3:0] PH_CFG0  = 4'd6;
    localparam logic [3:0] PH_CFG1  = 4'd7;
    localparam logic [3:0] PH_OK    = 4'd8;
    localparam logic [3:0] PH_FAIL  = 4'd9;

    logic [3:0]       r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [3:0]       r_skip, n_skip;
    logic [7:0]       r_codec, n_codec;
    logic [7:0]       r_cfg0, n_cfg0;
    logic [7:0]       r_cfg1, n_cfg1;
    logic [LEN_W-1:0] r_offset, n_offset;

    logic [3:0]       phase_c;
    logic [POS_W-1:0] pos_c;
    logic [CW-1:0]    pos_w;
    logic [CW-1:0]    len_c;
    logic [CW-1:0]    off_w;
    logic [CW-1:0]    size_diff;
    logic [LEN_W-1:0] size_out;
    logic [3:0]       skip_dec;
    logic [3:0]       idx;
    logic [7:0]       b;
    logic             active;
    logic             last;

    assign b       = i_item.data_byte;
    // A first byte restarts the walk before it is taken
    assign phase_c = i_item.first_byte ? PH_SEEK4 : r_phase;
    assign pos_c   = i_item.first_byte ? '0 : r_pos;
    assign pos_w   = CW'(pos_c);

    // Length clipped to the position range
    always_comb begin
        if (CW'(i_length) > CW'(MAX_DESCRIPTOR_BYTES)) begin
            len_c = CW'(MAX_DESCRIPTOR_BYTES);
        end else begin
            len_c = CW'(i_length);
        end
    end

    assign active   = (len_c != '0) && (pos_w < len_c);
    assign skip_dec = r_skip - 4'd1;
    assign n_pos    = (pos_c < POS_W'(MAX_DESCRIPTOR_BYTES)) ? pos_c + POS_W'(1) : pos_c;

    // Phase walk and held fields
    always_comb begin
        n_phase  = phase_c;
        n_skip   = r_skip;
        n_codec  = r_codec;
        n_cfg0   = r_cfg0;
        n_cfg1   = r_cfg1;
        n_offset = r_offset;
        if (active) begin
            unique case (phase_c)
                PH_SEEK4: begin
                    if (b == TAG_DEC_CONFIG) n_phase = PH_SIZE4;
                end
                PH_SIZE4: begin
                    if (!b[7]) n_phase = PH_CODEC;
                end
                PH_CODEC: begin
                    n_codec = b;
                    n_skip  = SKIP_AFTER_CODEC;
                    n_phase = PH_SKIP;
                end
                PH_SKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == 4'd0) n_phase = PH_TAG5;
                end
                PH_TAG5: begin
                    n_phase = (b == TAG_DEC_SPECIFIC) ? PH_SIZE5 : PH_FAIL;
                end
                PH_SIZE5: begin
                    if (!b[7]) n_phase = PH_CFG0;
                end
                PH_CFG0: begin
                    n_cfg0   = b;
                    n_offset = pos_w[LEN_W-1:0];
                    n_phase  = PH_CFG1;
                end
                PH_CFG1: begin
                    n_cfg1  = b;
                    n_phase = PH_OK;
                end
                default: begin
                    n_phase = phase_c;
                end
            endcase
        end
    end

    // Last byte: zero length ends at position zero
    assign last = (len_c == '0) ? (pos_w == '0) : (active && (pos_w == len_c - CW'(1)));

    // Bytes left after the config start, floored at two
    assign off_w     = CW'(n_offset);
    assign size_diff = len_c - off_w - CW'(1);
    always_comb begin
        if (off_w >= len_c || size_diff < CW'(MIN_CONFIG_SIZE)) begin
            size_out = MIN_CONFIG_SIZE;
        end else begin
            size_out = size_diff[LEN_W-1:0];
        end
    end

    // Result item
    assign idx = {n_cfg0[2:0], n_cfg1[7]};
    always_comb begin
        o_res = '0;
        if (len_c != '0 && n_phase == PH_OK) begin
            o_res.status         = STATUS_OK;
            o_res.codec_id       = n_codec;
            o_res.object_type    = n_cfg0[7:3];
            o_res.rate_index     = idx;
            o_res.sample_rate    = rate_lookup(idx);
            o_res.channel_config = n_cfg1[6:3];
            o_res.config_offset  = n_offset;
            o_res.config_size    = size_out;
        end else begin
            o_res.status = STATUS_FAIL;
        end
    end

    assign o_res_valid = i_step && last;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK4;
            r_pos   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
        end
    end

    // Held fields
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_skip   <= n_skip;
            r_codec  <= n_codec;
            r_cfg0   <= n_cfg0;
            r_cfg1   <= n_cfg1;
            r_offset <= n_offset;
        end
    end

endmodule

FILE: hw/rtl/esds_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esds_out_reg
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module esds_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  esds_pkg::t_out_item  i_res,
    output logic                 o_free,
    output logic                 o_valid,
    input  logic                 i_stall,
    output esds_pkg::t_out_item  o_res
);
    import esds_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_out_item r_res;

    // Free when empty or its result leaves on this edge
    assign o_free  = !r_valid || !i_stall;
    assign n_valid = i_load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: hw/rtl/esds_audio_config_parser.sv
`timescale 1ns / 1ps
// Path: a transferred byte is held in the input register; on a descriptor's
// last byte the parse stage loads the result into the output register.
// Throughput: one byte per cycle while the result register is free; the parse
// state updates once per byte. Reset: synchronous, active low; clears valids,
// parse phase, byte position and the length register. No clearing pass.
// ----------------------------------------------------------------------------
// esds_audio_config_parser
// Walks an esds descriptor one byte per transfer and reports the audio
// specific config (or a failure) on the descriptor's last byte.
// ----------------------------------------------------------------------------
module esds_audio_config_parser #(
    parameter int unsigned MAX_DESCRIPTOR_BYTES = 4095
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Byte channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  esds_pkg::t_in_item          i_in_data,
    // Result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output esds_pkg::t_out_item         o_out_data,
    // Length register write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [esds_pkg::LEN_W-1:0]  i_cfg_data
);
    import esds_pkg::*;

    logic [LEN_W-1:0] r_length;
    logic             s1_valid;
    t_in_item         s1_item;
    logic             out_free;
    logic             advance;
    logic             res_valid;
    t_out_item        res;

    // Length register, always writable
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_length <= i_cfg_data;
        end
    end

    // A held byte is parsed when the result register can take a result
    assign advance = s1_valid && out_free;

    esds_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (i_in_data),
        .i_advance (advance),
        .o_valid   (s1_valid),
        .o_item    (s1_item)
    );

    esds_parse #(
        .MAX_DESCRIPTOR_BYTES (MAX_DESCRIPTOR_BYTES)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_item      (s1_item),
        .i_length    (r_length),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    esds_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (o_out_data)
    );

endmodule
